@@ sv/sflf_pkg.sv @@
// shared types, constants and a helper function for the sine lfo flanger
`timescale 1ns / 1ps

package sflf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DLY_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN    = 2'd2;

  // register reset values
  localparam logic [9:0]         BASE_DELAY_RST  = 10'd512;
  localparam logic [15:0]        SWEEP_DEPTH_RST = 16'd16384;
  localparam logic signed [15:0] WET_GAIN_RST    = 16'sd16384;

  // pi/2 in unsigned q62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // one item handed from front to back: input sample and clamped delay
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [DLY_W-1:0]           delay;
  } work_t;

  // (a * b) >> 62, used only while building the sine table
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

endpackage

@@ sv/sine_lfo_flanger.sv @@
// top level of the sine lfo flanger
`timescale 1ns / 1ps

// Flanger with a sine LFO. Each input item is one signed 16-bit sample and gives
// one output item: the input plus the delayed sample scaled by the Q15 wet gain,
// saturated to 16 bits. The delay is base_delay plus (sweep_depth * sine) >> 16,
// clamped to 1 .. DELAY_DEPTH-1, and the sine table steps one entry per item.
// The front end reads the sine rom, multiplies by the depth and clamps the delay,
// and hands its result through a two-entry queue to the back end, which goes
// through queue pop, delay line read and write, gain multiply and saturating add;
// the back end sequencer and its single delay line access per item set the
// sustained rate, and the back end takes no new item from the queue before it is
// through with the last one. The output register lets the back end work on the
// next item while a result waits. No clearing pass runs after reset: delay line
// entries not yet written since reset read as zero.
// Configuration writes take effect at once and are meant for idle periods.

module sine_lfo_flanger import sflf_pkg::*; #(
  parameter int DELAY_DEPTH = 1024,
  parameter int LFO_ENTRIES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   in_sample_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_sample_out,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  logic [9:0]         base_delay_r, base_delay_nxt;
  logic [15:0]        sweep_depth_r, sweep_depth_nxt;
  logic signed [15:0] wet_gain_r, wet_gain_nxt;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  work_t q_wdata;
  work_t q_rdata;

  always_comb begin
    base_delay_nxt  = base_delay_r;
    sweep_depth_nxt = sweep_depth_r;
    wet_gain_nxt    = wet_gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_DELAY:  base_delay_nxt  = cfg_data[9:0];
        REG_SWEEP_DEPTH: sweep_depth_nxt = cfg_data;
        REG_WET_GAIN:    wet_gain_nxt    = $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r  <= BASE_DELAY_RST;
      sweep_depth_r <= SWEEP_DEPTH_RST;
      wet_gain_r    <= WET_GAIN_RST;
    end else begin
      base_delay_r  <= base_delay_nxt;
      sweep_depth_r <= sweep_depth_nxt;
      wet_gain_r    <= wet_gain_nxt;
    end
  end

  sflf_front #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .LFO_ENTRIES (LFO_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .base_delay   (base_delay_r),
    .sweep_depth  (sweep_depth_r),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  sflf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  sflf_back #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_data         (q_rdata),
    .wet_gain       (wet_gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

endmodule

@@ sv/sflf_front.sv @@
// front end: item intake, sine rom lookup, depth multiply and delay clamp
`timescale 1ns / 1ps

module sflf_front import sflf_pkg::*; #(
  parameter int DELAY_DEPTH = 1024,
  parameter int LFO_ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [9:0]                 base_delay,
  input  logic [15:0]                sweep_depth,
  output logic                       q_push,
  output work_t                      q_data,
  input  logic                       q_full
);

  localparam int PW = $clog2(LFO_ENTRIES);
  localparam logic [PW-1:0] PHASE_LAST = PW'(LFO_ENTRIES - 1);
  localparam logic signed [17:0] DLY_MIN = 18'sd1;
  localparam logic signed [17:0] DLY_MAX = 18'(DELAY_DEPTH - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  // angle step per table entry, whole part and remainder
  localparam logic [63:0] X_STEP = HALF_PI_Q62 / 64'(LFO_ENTRIES);
  localparam logic [63:0] X_REM  = HALF_PI_Q62 % 64'(LFO_ENTRIES);

  typedef logic signed [15:0] rom_t [LFO_ENTRIES];
  typedef logic [63:0] den_t [60];

  // taylor series divisors (2k) * (2k + 1)
  function automatic den_t taylor_den();
    den_t d;
    for (int k = 0; k < 60; k++) begin
      d[k] = 64'(2 * k) * 64'(2 * k + 1);
    end
    return d;
  endfunction

  localparam den_t TAYLOR_DEN = taylor_den();

  // trunc(32767 * sin((pi/2) * num / LFO_ENTRIES)) for 0 < num < LFO_ENTRIES
  function automatic logic [15:0] quarter_sine(input logic [63:0] num);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] res;
    x = X_STEP * num + (X_REM * num) / 64'(LFO_ENTRIES);
    x2 = mul_q62(x, x);
    term = x;
    sum = x;
    for (int k = 1; k < 60; k++) begin
      if (term != 64'd0) begin
        term = mul_q62(term, x2) / TAYLOR_DEN[k];
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    hi = sum >> 32;
    lo = sum & 64'hFFFF_FFFF;
    a = hi * 64'd32767;
    b = (lo * 64'd32767) >> 32;
    res = (a + b) >> 30;
    return res[15:0];
  endfunction

  function automatic logic signed [15:0] sine_entry(input int i);
    logic [63:0] four;
    logic [63:0] q;
    logic [63:0] r;
    logic [15:0] v;
    four = 64'(4 * i);
    q = four / 64'(LFO_ENTRIES);
    r = four % 64'(LFO_ENTRIES);
    if (r == 64'd0) begin
      v = (q == 64'd1) ? 16'd32767 : (q == 64'd3) ? -16'd32767 : 16'd0;
    end else if (q == 64'd0) begin
      v = quarter_sine(r);
    end else if (q == 64'd1) begin
      v = quarter_sine(64'(LFO_ENTRIES) - r);
    end else if (q == 64'd2) begin
      v = -quarter_sine(r);
    end else begin
      v = -quarter_sine(64'(LFO_ENTRIES) - r);
    end
    return $signed(v);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < LFO_ENTRIES; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [1:0]                 state_r, state_nxt;
  logic [PW-1:0]              phase_r, phase_nxt;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [15:0]         sine_r;
  logic signed [32:0]         prod_r;
  logic signed [17:0]         dly_sum;
  logic signed [17:0]         dly_cl;
  logic                       accept;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // floor of depth * sine / 2^16 is the top bits of the product
  assign dly_sum = $signed({8'd0, base_delay}) + $signed({prod_r[32], prod_r[32:16]});

  always_comb begin
    if (dly_sum < DLY_MIN) begin
      dly_cl = DLY_MIN;
    end else if (dly_sum > DLY_MAX) begin
      dly_cl = DLY_MAX;
    end else begin
      dly_cl = dly_sum;
    end
  end

  assign q_data.sample = samp_r;
  assign q_data.delay  = dly_cl[DLY_W-1:0];
  assign q_push        = (state_r == F_PUSH) && !q_full;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MUL;
          phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // sine rom with registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= in_sample_in;
      sine_r <= SINE_ROM[phase_r];
    end
    if (state_r == F_MUL) begin
      prod_r <= $signed({1'b0, sweep_depth}) * sine_r;
    end
  end

endmodule

@@ sv/sflf_queue.sv @@
// two-entry queue between front and back
`timescale 1ns / 1ps

module sflf_queue import sflf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  localparam int QD = 2;

  work_t      ent_r [QD];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'(QD));
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule

@@ sv/sflf_back.sv @@
// back end: delay line access, wet gain multiply, saturating mix and output register
`timescale 1ns / 1ps

module sflf_back import sflf_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  work_t                      q_data,
  input  logic signed [15:0]         wet_gain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DELAY_DEPTH);
  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ADDR = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_SUM  = 2'd3;

  logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic [1:0]                 state_r, state_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic                       wrapped_r, wrapped_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic [AW-1:0]              dly_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       hit_r;
  logic signed [31:0]         wet_r;
  logic [AW:0]                rd_wrap;
  logic [AW-1:0]              rd_addr;
  logic                       hit;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [17:0]         sum;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic                       can_load;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_data_r;

  // read address behind the write pointer, circular
  assign rd_wrap = {1'b0, wp_r} + DEPTH_W - {1'b0, dly_r};
  always_comb begin
    if (wp_r >= dly_r) begin
      rd_addr = wp_r - dly_r;
    end else begin
      rd_addr = rd_wrap[AW-1:0];
    end
  end

  // the memory has no reset: reads of entries never written since reset are masked to zero
  assign hit     = wrapped_r || (rd_addr < wp_r);
  assign delayed = hit_r ? rd_data_r : '0;

  assign sum = {{2{samp_r[SAMPLE_W-1]}}, samp_r} + {wet_r[31], wet_r[31:15]};
  always_comb begin
    if (sum > SAT_MAX) begin
      sum_sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (sum < SAT_MIN) begin
      sum_sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_ADDR;
        end
      end
      B_ADDR: begin
        state_nxt = B_MUL;
        if (wp_r == WP_LAST) begin
          wp_nxt      = '0;
          wrapped_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + 1'b1;
        end
      end
      B_MUL: begin
        state_nxt = B_SUM;
      end
      B_SUM: begin
        if (can_load) begin
          state_nxt     = B_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // delay line: one read and one write per item, read data registered
  always_ff @(posedge clk) begin
    if (state_r == B_ADDR) begin
      rd_data_r <= mem[rd_addr];
      mem[wp_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      samp_r <= q_data.sample;
      dly_r  <= q_data.delay[AW-1:0];
    end
    if (state_r == B_ADDR) begin
      hit_r <= hit;
    end
    if (state_r == B_MUL) begin
      wet_r <= wet_gain * delayed;
    end
    if (state_r == B_SUM && can_load) begin
      out_data_r <= sum_sat;
    end
  end

endmodule

@@ sv/sflf_checker.sv @@
// port-level checker for the sine lfo flanger, bound to the top level
`timescale 1ns / 1ps

module sflf_checker import sflf_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic signed [SAMPLE_W-1:0] in_sample_in,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample_out
);

  logic [3:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken in whose results are not yet delivered
  always_comb begin
    pend_nxt = pend_r + {3'd0, in_acc} - {3'd0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("stalled output item changed");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready again right after an item was taken");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("output item without a pending input item");

  a_sample_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !$isunknown(in_sample_in))
    else $error("input item taken with unknown sample");

endmodule

bind sine_lfo_flanger sflf_checker u_sflf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_sample_in   (in_sample_in),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);
